// ===== rtl/core/rqr_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and codes for the ready queue with remove.
// Depends on nothing; every other file of the block but rqr_ram imports it.
package rqr_pkg;

  localparam int QueueDepthDef = 16;
  localparam int IdWidthDef    = 8;

  localparam logic [1:0] CMD_ENQ = 2'd0;
  localparam logic [1:0] CMD_DEQ = 2'd1;
  localparam logic [1:0] CMD_REM = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_EMPTY    = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] thread_id;
  } in_t;

  typedef struct packed {
    logic [7:0] out_id;
    logic [1:0] status;
    logic [4:0] occupancy;
  } out_t;

endpackage

// ===== rtl/core/rqr_ram.sv =====
`timescale 1ns / 1ps
// Slot storage for the ready queue: one write port, one read port with
// registered read data. Depends on nothing.
module rqr_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/rqr_ctrl.sv =====
`timescale 1ns / 1ps
// Command sequencer of the ready queue: scans the slots with one comparator
// and closes gaps one slot per cycle. Depends on rqr_pkg and drives rqr_ram.
module rqr_ctrl #(
  parameter int QUEUE_DEPTH = rqr_pkg::QueueDepthDef,
  parameter int ID_WIDTH    = rqr_pkg::IdWidthDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  rqr_pkg::in_t                   in_data_i,
  output logic                           res_valid_o,
  input  logic                           res_ready_i,
  output rqr_pkg::out_t                  res_o,
  output logic                           mem_we_o,
  output logic [$clog2(QUEUE_DEPTH)-1:0] mem_waddr_o,
  output logic [ID_WIDTH-1:0]            mem_wdata_o,
  output logic                           mem_re_o,
  output logic [$clog2(QUEUE_DEPTH)-1:0] mem_raddr_o,
  input  logic [ID_WIDTH-1:0]            mem_rdata_i
);

  import rqr_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_SHIFT = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0]          state_q, state_d;
  logic [CW-1:0]       count_q, count_d;
  logic [CW-1:0]       ptr_q, ptr_d;
  logic                rd_vld_q, rd_vld_d;
  logic [AW-1:0]       rd_addr_q, rd_addr_d;
  logic                deq_q, deq_d;
  logic [ID_WIDTH-1:0] id_q, id_d;
  out_t                res_q, res_d;
  logic                accept;
  logic                issue;
  logic                match;
  logic                full;

  assign accept = in_valid_i && (state_q == S_IDLE);
  assign issue  = ptr_q < count_q;
  assign match  = deq_q || (mem_rdata_i == id_q);
  assign full   = count_q == CW'(QUEUE_DEPTH);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    ptr_d       = ptr_q;
    rd_vld_d    = 1'b0;
    rd_addr_d   = rd_addr_q;
    deq_d       = deq_q;
    id_d        = id_q;
    res_d       = res_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = '0;
    mem_wdata_o = mem_rdata_i;
    mem_re_o    = 1'b0;
    mem_raddr_o = ptr_q[AW-1:0];
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          id_d            = ID_WIDTH'(in_data_i.thread_id);
          deq_d           = in_data_i.cmd == CMD_DEQ;
          ptr_d           = '0;
          res_d.out_id    = '0;
          res_d.status    = ST_OK;
          res_d.occupancy = 5'(count_q);
          state_d         = S_DONE;
          case (in_data_i.cmd)
            CMD_ENQ: begin
              if (full) begin
                res_d.status = ST_FULL;
              end else begin
                mem_we_o        = 1'b1;
                mem_waddr_o     = count_q[AW-1:0];
                mem_wdata_o     = ID_WIDTH'(in_data_i.thread_id);
                count_d         = count_q + 1'b1;
                res_d.occupancy = 5'(count_q + 1'b1);
              end
            end
            CMD_DEQ: begin
              if (count_q == '0) begin
                res_d.status = ST_EMPTY;
              end else begin
                state_d = S_SCAN;
              end
            end
            CMD_REM: begin
              state_d = S_SCAN;
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end
      S_SCAN: begin
        mem_re_o  = issue;
        rd_vld_d  = issue;
        rd_addr_d = ptr_q[AW-1:0];
        ptr_d     = ptr_q + CW'(issue);
        if (rd_vld_q && match) begin
          res_d.out_id = deq_q ? 8'(mem_rdata_i) : '0;
          state_d      = S_SHIFT;
        end else if (!rd_vld_q && !issue) begin
          res_d.status = ST_NOTFOUND;
          state_d      = S_DONE;
        end
      end
      S_SHIFT: begin
        mem_re_o  = issue;
        rd_vld_d  = issue;
        rd_addr_d = ptr_q[AW-1:0];
        ptr_d     = ptr_q + CW'(issue);
        if (rd_vld_q) begin
          mem_we_o    = 1'b1;
          mem_waddr_o = rd_addr_q - 1'b1;
          mem_wdata_o = mem_rdata_i;
        end else if (!issue) begin
          count_d         = count_q - 1'b1;
          res_d.occupancy = 5'(count_q - 1'b1);
          state_d         = S_DONE;
        end
      end
      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      ptr_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      ptr_q    <= ptr_d;
      rd_vld_q <= rd_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_addr_q <= rd_addr_d;
    deq_q     <= deq_d;
    id_q      <= id_d;
    res_q     <= res_d;
  end

  assign in_stall_o  = state_q != S_IDLE;
  assign res_valid_o = state_q == S_DONE;
  assign res_o       = res_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(QUEUE_DEPTH))
    else $error("entry count exceeds the queue depth");

  a_shift_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SHIFT && rd_vld_q) |-> rd_addr_q != '0)
    else $error("gap close reads the head slot");

  a_enq_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_data_i.cmd == CMD_ENQ && !full)
      |=> count_q == CW'($past(count_q) + 1'b1))
    else $error("enqueue did not grow the queue by one");

  a_remove_shrink: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SHIFT && !rd_vld_q && !issue)
      |=> count_q == CW'($past(count_q) - 1'b1))
    else $error("removal did not shrink the queue by one");

  a_done_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE) |-> res_q.occupancy == 5'(count_q))
    else $error("reported occupancy differs from the entry count");

endmodule

// ===== rtl/core/ready_queue_with_remove.sv =====
`timescale 1ns / 1ps
// Ready queue of thread identifiers with enqueue, dequeue and remove.
// Depends on rqr_pkg, rqr_ram and rqr_ctrl.
//
// The command channel takes one item (cmd, thread_id) when in_valid_i is high
// and in_stall_o is low. The block works on one command at a time and holds
// in_stall_o high until that command's result has moved to the output
// register. Every command gives exactly one result item (out_id, status,
// occupancy) on the result channel, taken when out_valid_o is high and
// out_stall_i is low.
// An enqueue, a rejected enqueue, a dequeue on an empty queue and an unused
// command go straight from acceptance to a valid result. A dequeue or a
// remove walks the stored entries through the single memory read port, one
// entry per cycle for the search and one per cycle to close the gap.
// The output register lets a new command be accepted while the previous
// result is still stalled; the new result waits in the sequencer until the
// register frees up. Reset empties the queue at once; the slot memory itself
// is not cleared and needs no clearing pass.
module ready_queue_with_remove #(
  parameter int QUEUE_DEPTH = rqr_pkg::QueueDepthDef,
  parameter int ID_WIDTH    = rqr_pkg::IdWidthDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  rqr_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output rqr_pkg::out_t out_data_o
);

  import rqr_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);

  logic                res_valid;
  logic                res_ready;
  out_t                res;
  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  logic [ID_WIDTH-1:0] mem_wdata;
  logic                mem_re;
  logic [AW-1:0]       mem_raddr;
  logic [ID_WIDTH-1:0] mem_rdata;
  logic                out_valid_q, out_valid_d;
  out_t                out_data_q;

  rqr_ram #(
    .DEPTH(QUEUE_DEPTH),
    .WIDTH(ID_WIDTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  rqr_ctrl #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .ID_WIDTH   (ID_WIDTH)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .res_valid_o(res_valid),
    .res_ready_i(res_ready),
    .res_o      (res),
    .mem_we_o   (mem_we),
    .mem_waddr_o(mem_waddr),
    .mem_wdata_o(mem_wdata),
    .mem_re_o   (mem_re),
    .mem_raddr_o(mem_raddr),
    .mem_rdata_i(mem_rdata)
  );

  assign res_ready = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
